FILE: hw/rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// shared types and constants of the bilinear rgba scaler
// ----------------------------------------------------------------------------
package brs_pkg;

    // field widths
    localparam int CRD_W  = 12;
    localparam int CHAN_W = 8;
    localparam int SIZE_W = 9;
    localparam int STEP_W = 25;
    localparam int POS_W  = CRD_W + STEP_W;
    localparam int FRAC_W = 8;
    localparam int WGT_W  = 2 * (FRAC_W + 1) - 1;
    localparam int PROD_W = CHAN_W + WGT_W;
    localparam int PIX_W  = 4 * CHAN_W;
    localparam int TAPS   = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd3;

    // request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // control that travels with an item down the pipeline
    typedef struct packed {
        logic               valid;
        logic               sample;
        logic [CRD_W-1:0]   cx;
        logic [CRD_W-1:0]   cy;
    } t_ctl;

    // parity of the four taps, picks the bank for each tap
    typedef struct packed {
        logic x0;
        logic x1;
        logic y0;
        logic y1;
    } t_tap_par;

endpackage

FILE: hw/rtl/brs_ram.sv
// ----------------------------------------------------------------------------
// brs_ram
// generic one-write one-read memory with registered read
// ----------------------------------------------------------------------------
module brs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/brs_axis.sv
// ----------------------------------------------------------------------------
// brs_axis
// position of one axis: coordinate times step, then clamped taps and fraction
// ----------------------------------------------------------------------------
module brs_axis #(
    parameter int MAX_SIZE = 256
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [brs_pkg::CRD_W-1:0]   i_coord,
    input  logic [brs_pkg::STEP_W-1:0]  i_step,
    input  logic [$clog2(MAX_SIZE)-1:0] i_last,
    output logic [$clog2(MAX_SIZE)-1:0] o_t0,
    output logic [$clog2(MAX_SIZE)-1:0] o_t1,
    output logic [brs_pkg::FRAC_W-1:0]  o_frac
);

    localparam int IW  = $clog2(MAX_SIZE);
    localparam int IPW = brs_pkg::POS_W - 16;

    logic [brs_pkg::POS_W-1:0]  r_pos;
    logic [IPW-1:0]             ip;
    logic [IW-1:0]              i0;
    logic [IW-1:0]              i1;
    logic [IW-1:0]              r_t0;
    logic [IW-1:0]              r_t1;
    logic [brs_pkg::FRAC_W-1:0] r_frac;

    // q21.16 position
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos <= brs_pkg::POS_W'(i_coord) * brs_pkg::POS_W'(i_step);
        end
    end

    // clamp integer part and its neighbor to the last index
    always_comb begin
        ip = r_pos[brs_pkg::POS_W-1:16];
        i0 = (ip > IPW'(i_last)) ? i_last : ip[IW-1:0];
        i1 = (i0 == i_last) ? i_last : i0 + IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0   <= i0;
            r_t1   <= i1;
            r_frac <= r_pos[15:8];
        end
    end

    assign o_t0   = r_t0;
    assign o_t1   = r_t1;
    assign o_frac = r_frac;

endmodule

FILE: hw/rtl/brs_lane.sv
// ----------------------------------------------------------------------------
// brs_lane
// one color channel: four weighted taps, summed and truncated
// ----------------------------------------------------------------------------
module brs_lane (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [brs_pkg::TAPS-1:0][brs_pkg::CHAN_W-1:0] i_tap,
    input  logic [brs_pkg::TAPS-1:0][brs_pkg::WGT_W-1:0]  i_wgt,
    output logic [brs_pkg::CHAN_W-1:0]                    o_chan
);

    logic [brs_pkg::TAPS-1:0][brs_pkg::PROD_W-1:0] r_prod;
    logic [brs_pkg::PROD_W+1:0]                    sum;
    logic [brs_pkg::CHAN_W-1:0]                    r_chan;

    // tap products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int t = 0; t < brs_pkg::TAPS; t++) begin
                r_prod[t] <= brs_pkg::PROD_W'(i_tap[t]) * brs_pkg::PROD_W'(i_wgt[t]);
            end
        end
    end

    // sum and drop the 16 fraction bits
    always_comb begin
        sum = (brs_pkg::PROD_W+2)'(r_prod[0]) + (brs_pkg::PROD_W+2)'(r_prod[1])
            + (brs_pkg::PROD_W+2)'(r_prod[2]) + (brs_pkg::PROD_W+2)'(r_prod[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan <= sum[23:16];
        end
    end

    assign o_chan = r_chan;

endmodule

FILE: hw/rtl/bilinear_rgba_scaler.sv
// ----------------------------------------------------------------------------
// bilinear_rgba_scaler
// bilinear rgba resampler with a banked source store and four channel lanes
// ----------------------------------------------------------------------------
// A load transfer (tuser 0) writes one source pixel; a sample transfer
// (tuser 1) returns one interpolated pixel tagged with its target
// coordinate. The block takes one transfer per cycle unless the sink
// stalls, loads and samples mixed freely. That rate comes from the source
// store being split into four banks by row and column parity, so the four
// taps of a sample are read in the same cycle, and from one multiplier per
// tap in each channel lane. Loads and samples reach the store in their
// arrival order, so a sample sees every load taken before it. The output
// register holds a result while the sink stalls and the whole pipeline
// stalls with it. Configuration is taken any time and must only be
// written while the block is idle.
module bilinear_rgba_scaler #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // coord_x, coord_y, in_red, in_green, in_blue, in_alpha
    input  logic [55:0]                     i_s_tdata,
    // req_type
    input  logic                            i_s_tuser,
    // master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // target_x, target_y, out_red, out_green, out_blue, out_alpha
    output logic [55:0]                     o_m_tdata,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [brs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [brs_pkg::STEP_W-1:0]      i_cfg_data
);

    localparam int IWX    = $clog2(MAX_SRC_WIDTH);
    localparam int IWY    = $clog2(MAX_SRC_HEIGHT);
    localparam int HALF_W = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int DEPTH  = HALF_W * HALF_H;
    localparam int AW     = $clog2(DEPTH);
    localparam int SZ_W   = 14;

    localparam int CW = brs_pkg::CRD_W;
    localparam int HW = brs_pkg::CHAN_W;
    localparam int PW = brs_pkg::PIX_W;
    localparam int WW = brs_pkg::WGT_W;

    // configuration registers
    logic [brs_pkg::SIZE_W-1:0] r_src_width;
    logic [brs_pkg::SIZE_W-1:0] r_src_height;
    logic [brs_pkg::STEP_W-1:0] r_step_x;
    logic [brs_pkg::STEP_W-1:0] r_step_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 9'd256;
            r_src_height <= 9'd256;
            r_step_x     <= 25'd65536;
            r_step_y     <= 25'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                brs_pkg::REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[brs_pkg::SIZE_W-1:0];
                brs_pkg::REG_SRC_HEIGHT: r_src_height <= i_cfg_data[brs_pkg::SIZE_W-1:0];
                brs_pkg::REG_STEP_X:     r_step_x     <= i_cfg_data;
                brs_pkg::REG_STEP_Y:     r_step_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // last usable column and row after clamping the size
    logic [SZ_W-1:0] w_ext;
    logic [SZ_W-1:0] h_ext;
    logic [IWX-1:0]  last_x;
    logic [IWY-1:0]  last_y;

    always_comb begin
        w_ext = SZ_W'(r_src_width);
        h_ext = SZ_W'(r_src_height);
        if (w_ext == '0) begin
            last_x = '0;
        end else if (w_ext > SZ_W'(MAX_SRC_WIDTH)) begin
            last_x = IWX'(MAX_SRC_WIDTH - 1);
        end else begin
            last_x = IWX'(w_ext - SZ_W'(1));
        end
        if (h_ext == '0) begin
            last_y = '0;
        end else if (h_ext > SZ_W'(MAX_SRC_HEIGHT)) begin
            last_y = IWY'(MAX_SRC_HEIGHT - 1);
        end else begin
            last_y = IWY'(h_ext - SZ_W'(1));
        end
    end

    // pipeline advance
    brs_pkg::t_ctl r_ctl1, r_ctl2, r_ctl3, r_ctl4, r_ctl5;
    logic          en;

    assign en         = !r_ctl5.valid || i_m_tready;
    assign o_s_tready = en;

    // stage 1: item registers, positions in the axis units
    logic [PW-1:0] r_pix1, r_pix2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
        end else if (en) begin
            r_ctl1.valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl1.sample <= i_s_tuser;
            r_ctl1.cx     <= i_s_tdata[11:0];
            r_ctl1.cy     <= i_s_tdata[23:12];
            r_pix1        <= i_s_tdata[55:24];
        end
    end

    // stage 2: taps and fractions
    logic [IWX-1:0]             x0, x1;
    logic [IWY-1:0]             y0, y1;
    logic [brs_pkg::FRAC_W-1:0] fx, fy;

    brs_axis #(.MAX_SIZE(MAX_SRC_WIDTH)) u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_s_tdata[11:0]),
        .i_step  (r_step_x),
        .i_last  (last_x),
        .o_t0    (x0),
        .o_t1    (x1),
        .o_frac  (fx)
    );

    brs_axis #(.MAX_SIZE(MAX_SRC_HEIGHT)) u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_s_tdata[23:12]),
        .i_step  (r_step_y),
        .i_last  (last_y),
        .o_t0    (y0),
        .o_t1    (y1),
        .o_frac  (fy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2.valid <= 1'b0;
        end else if (en) begin
            r_ctl2.valid <= r_ctl1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl2.sample <= r_ctl1.sample;
            r_ctl2.cx     <= r_ctl1.cx;
            r_ctl2.cy     <= r_ctl1.cy;
            r_pix2        <= r_pix1;
        end
    end

    // bank addressing: column and row of each parity
    logic [1:0][IWX-1:0] col_sel;
    logic [1:0][IWY-1:0] row_sel;
    logic                load_ok;
    logic [IWX-1:0]      wx;
    logic [IWY-1:0]      wy;
    logic [AW-1:0]       waddr;
    logic                we_any;

    always_comb begin
        col_sel[0] = x0[0] ? x1 : x0;
        col_sel[1] = x0[0] ? x0 : x1;
        row_sel[0] = y0[0] ? y1 : y0;
        row_sel[1] = y0[0] ? y0 : y1;
        load_ok = ({1'b0, r_ctl2.cx} < (CW+1)'(MAX_SRC_WIDTH))
               && ({1'b0, r_ctl2.cy} < (CW+1)'(MAX_SRC_HEIGHT));
        wx     = r_ctl2.cx[IWX-1:0];
        wy     = r_ctl2.cy[IWY-1:0];
        waddr  = AW'(AW'(wy >> 1) * AW'(HALF_W) + AW'(wx >> 1));
        we_any = en && r_ctl2.valid && (r_ctl2.sample == brs_pkg::REQ_LOAD) && load_ok;
    end

    // four parity banks, read together
    logic [1:0][1:0][PW-1:0] rd_data;
    logic [1:0][1:0]         bank_we;

    for (genvar by = 0; by < 2; by++) begin : g_row
        for (genvar bx = 0; bx < 2; bx++) begin : g_col
            logic [AW-1:0] raddr;

            assign raddr = AW'(AW'(row_sel[by] >> 1) * AW'(HALF_W)
                              + AW'(col_sel[bx] >> 1));
            assign bank_we[by][bx] = we_any && (wy[0] == 1'(by)) && (wx[0] == 1'(bx));

            brs_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_bank (
                .i_clk   (i_clk),
                .i_we    (bank_we[by][bx]),
                .i_waddr (waddr),
                .i_wdata (r_pix2),
                .i_re    (en),
                .i_raddr (raddr),
                .o_rdata (rd_data[by][bx])
            );
        end
    end

    // stage 3: bank data, weights and tap parities
    logic [brs_pkg::FRAC_W:0] fx_c, fy_c;
    logic [WW-1:0]            r_w00, r_w10, r_w01, r_w11;
    brs_pkg::t_tap_par        r_par;

    assign fx_c = 9'd256 - 9'(fx);
    assign fy_c = 9'd256 - 9'(fy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3.valid <= 1'b0;
        end else if (en) begin
            r_ctl3.valid <= r_ctl2.valid && (r_ctl2.sample == brs_pkg::REQ_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl3.sample <= r_ctl2.sample;
            r_ctl3.cx     <= r_ctl2.cx;
            r_ctl3.cy     <= r_ctl2.cy;
            r_w00         <= WW'(fx_c) * WW'(fy_c);
            r_w10         <= WW'(fx) * WW'(fy_c);
            r_w01         <= WW'(fx_c) * WW'(fy);
            r_w11         <= WW'(fx) * WW'(fy);
            r_par.x0      <= x0[0];
            r_par.x1      <= x1[0];
            r_par.y0      <= y0[0];
            r_par.y1      <= y1[0];
        end
    end

    // pick each tap from its bank
    logic [PW-1:0]                   p00, p10, p01, p11;
    logic [brs_pkg::TAPS-1:0][WW-1:0] wgt;

    always_comb begin
        p00 = rd_data[r_par.y0][r_par.x0];
        p10 = rd_data[r_par.y0][r_par.x1];
        p01 = rd_data[r_par.y1][r_par.x0];
        p11 = rd_data[r_par.y1][r_par.x1];
        wgt = {r_w11, r_w01, r_w10, r_w00};
    end

    // stages 4 and 5: one lane per channel
    logic [3:0][HW-1:0] chan;

    for (genvar c = 0; c < 4; c++) begin : g_lane
        logic [brs_pkg::TAPS-1:0][HW-1:0] tap;

        assign tap = {p11[c*HW +: HW], p01[c*HW +: HW], p10[c*HW +: HW], p00[c*HW +: HW]};

        brs_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_tap  (tap),
            .i_wgt  (wgt),
            .o_chan (chan[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl4.valid <= 1'b0;
            r_ctl5.valid <= 1'b0;
        end else if (en) begin
            r_ctl4.valid <= r_ctl3.valid;
            r_ctl5.valid <= r_ctl4.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl4.sample <= r_ctl3.sample;
            r_ctl4.cx     <= r_ctl3.cx;
            r_ctl4.cy     <= r_ctl3.cy;
            r_ctl5.sample <= r_ctl4.sample;
            r_ctl5.cx     <= r_ctl4.cx;
            r_ctl5.cy     <= r_ctl4.cy;
        end
    end

    // merge lanes into the result transfer
    assign o_m_tvalid = r_ctl5.valid;
    assign o_m_tdata  = {chan[3], chan[2], chan[1], chan[0], r_ctl5.cy, r_ctl5.cx};

    // a pending result that is not taken stalls the input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl5.valid && !i_m_tready) |-> !o_s_tready)
        else $error("input ready while result stalled");

    // the four bilinear weights always add up to one
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl3.valid |-> ((19'(r_w00) + 19'(r_w10) + 19'(r_w01) + 19'(r_w11)) == 19'd65536))
        else $error("bilinear weights do not sum to one");

    // at most one bank written per cycle
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(bank_we))
        else $error("more than one bank written");

    // only a load ever writes the store
    a_write_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bank_we != '0) |-> (r_ctl2.valid && (r_ctl2.sample == brs_pkg::REQ_LOAD)))
        else $error("store written by a non-load item");

endmodule
